// ===== sv/table_file_header_parser_macros.svh =====
// assertion helpers shared by the parser modules
`ifndef TABLE_FILE_HEADER_PARSER_MACROS_SVH
`define TABLE_FILE_HEADER_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define TFHP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tfhp assertion failed");
`define TFHP_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("tfhp forbidden condition");
`else
`define TFHP_ASSERT(label, clk, rst, prop)
`define TFHP_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== sv/tfhp_pkg.sv =====
package tfhp_pkg;

   localparam int unsigned POS_W = 5;
   localparam logic [POS_W-1:0] LAST_POS = 5'd31;

   localparam logic [7:0]  SHORT_VERSION    = 8'h02;
   localparam logic [15:0] SHORT_HEADER_LEN = 16'd521;
   localparam logic [15:0] MIN_HEADER_LEN   = 16'd32;
   localparam logic [6:0]  ROLLOVER_RESET   = 7'd80;
   localparam logic [7:0]  YEAR_LIMIT       = 8'd100;
   localparam logic [11:0] YEAR_BASE_OLD    = 12'd1900;
   localparam logic [11:0] YEAR_BASE_NEW    = 12'd2000;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_SHORT      = 2'd1;
   localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;

   localparam logic [2:0] KIND_UNKNOWN = 3'd0;
   localparam logic [2:0] KIND_FAMILY1 = 3'd1;
   localparam logic [2:0] KIND_FAMILY2 = 3'd2;
   localparam logic [2:0] KIND_FAMILY3 = 3'd3;
   localparam logic [2:0] KIND_FAMILY4 = 3'd4;

   localparam int unsigned RSP_DATA_W = 120;

   typedef struct packed {
      logic [7:0]  version;
      logic [7:0]  year;
      logic [7:0]  month;
      logic [7:0]  day;
      logic [31:0] num_records;
      logic [15:0] hdr_size;
      logic [15:0] rec_size;
      logic [7:0]  flags;
      logic [7:0]  page_mark;
   } hdr_fields_type;

   typedef struct packed {
      logic emit;
      logic short_hdr;
   } cap_event_type;

   // status sits in the low bits
   typedef struct packed {
      logic [13:0] code_page;
      logic [7:0]  update_day;
      logic [7:0]  update_month;
      logic [11:0] full_year;
      logic [15:0] record_bytes;
      logic [15:0] header_bytes;
      logic [31:0] record_total;
      logic        index_present;
      logic        container_present;
      logic        memo_present;
      logic [2:0]  format_kind;
      logic [1:0]  status;
   } rsp_fields_type;

   localparam int unsigned RSP_FIELDS_W = $bits(rsp_fields_type);

   function automatic logic [13:0] page_of_mark(input logic [7:0] m);
      logic [13:0] p;
      unique case (m)
         8'h01: p = 14'd437;
         8'h02: p = 14'd850;
         8'h03: p = 14'd1252;
         8'h04: p = 14'd10000;
         8'h64: p = 14'd852;
         8'h65: p = 14'd866;
         8'h66: p = 14'd865;
         8'h67: p = 14'd861;
         8'h68: p = 14'd895;
         8'h69: p = 14'd620;
         8'h6A: p = 14'd737;
         8'h6B: p = 14'd857;
         8'h78: p = 14'd950;
         8'h79: p = 14'd949;
         8'h7A: p = 14'd936;
         8'h7B: p = 14'd932;
         8'h7C: p = 14'd874;
         8'h7D: p = 14'd1255;
         8'h7E: p = 14'd1256;
         8'h96: p = 14'd10007;
         8'h97: p = 14'd10029;
         8'h98: p = 14'd10006;
         8'hC8: p = 14'd1250;
         8'hC9: p = 14'd1251;
         8'hCA: p = 14'd1254;
         8'hCB: p = 14'd1253;
         default: p = 14'd0;
      endcase
      return p;
   endfunction

   function automatic logic [2:0] kind_of_version(input logic [7:0] v);
      logic [2:0] k;
      priority if (v[2:0] == 3'b100) begin
         k = KIND_FAMILY3;
      end else begin
         unique case (v)
            8'h02, 8'hFB: k = KIND_FAMILY1;
            8'h03, 8'h43, 8'h63, 8'h83, 8'h8B, 8'hCB: k = KIND_FAMILY3;
            8'hF5: k = KIND_FAMILY2;
            8'h30, 8'h31, 8'h32: k = KIND_FAMILY4;
            default: k = KIND_UNKNOWN;
         endcase
      end
      return k;
   endfunction

   function automatic logic memo_of_version(input logic [7:0] v);
      logic mm;
      priority if (v[2:0] == 3'b100) begin
         mm = (v & 8'h88) != 8'h00;
      end else begin
         mm = (v == 8'h83) || (v == 8'h8B) || (v == 8'hF5);
      end
      return mm;
   endfunction

endpackage

// ===== sv/tfhp_capture.sv =====
`include "table_file_header_parser_macros.svh"

module tfhp_capture
   import tfhp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     data_byte,
   input  logic           last_byte,
   output hdr_fields_type fields,
   output cap_event_type  ev
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             sent_ff, sent_in;
   hdr_fields_type   fields_ff, fields_in;

   always_comb begin
      pos_in       = pos_ff;
      sent_in      = sent_ff;
      fields_in    = fields_ff;
      ev.emit      = 1'b0;
      ev.short_hdr = 1'b0;
      if (accept) begin
         if (sent_ff) begin
            if (last_byte) begin
               sent_in = 1'b0;
               pos_in  = '0;
            end
         end else begin
            if (pos_ff == '0) begin
               fields_in         = '0;
               fields_in.version = data_byte;
            end else if (fields_ff.version == SHORT_VERSION) begin
               unique case (pos_ff)
                  5'd1: fields_in.num_records[7:0]  = data_byte;
                  5'd2: fields_in.num_records[15:8] = data_byte;
                  5'd3: fields_in.month             = data_byte;
                  5'd4: fields_in.day               = data_byte;
                  5'd5: fields_in.year              = data_byte;
                  5'd6: fields_in.rec_size[7:0]     = data_byte;
                  5'd7: fields_in.rec_size[15:8]    = data_byte;
                  default: ;
               endcase
            end else begin
               unique case (pos_ff)
                  5'd1:  fields_in.year               = data_byte;
                  5'd2:  fields_in.month              = data_byte;
                  5'd3:  fields_in.day                = data_byte;
                  5'd4:  fields_in.num_records[7:0]   = data_byte;
                  5'd5:  fields_in.num_records[15:8]  = data_byte;
                  5'd6:  fields_in.num_records[23:16] = data_byte;
                  5'd7:  fields_in.num_records[31:24] = data_byte;
                  5'd8:  fields_in.hdr_size[7:0]      = data_byte;
                  5'd9:  fields_in.hdr_size[15:8]     = data_byte;
                  5'd10: fields_in.rec_size[7:0]      = data_byte;
                  5'd11: fields_in.rec_size[15:8]     = data_byte;
                  5'd28: fields_in.flags              = data_byte;
                  5'd29: fields_in.page_mark          = data_byte;
                  default: ;
               endcase
            end
            if (pos_ff != LAST_POS) begin
               if (last_byte) begin
                  pos_in       = '0;
                  ev.emit      = 1'b1;
                  ev.short_hdr = 1'b1;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end else begin
               pos_in  = '0;
               sent_in = !last_byte;
               ev.emit = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         sent_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         sent_ff <= sent_in;
      end
      fields_ff <= fields_in;
   end

   assign fields = fields_ff;

   `TFHP_NEVER(a_no_emit_while_draining, clock, reset, ev.emit && sent_ff)
   `TFHP_ASSERT(a_pos_advances, clock, reset,
      accept && !sent_ff && !last_byte && (pos_ff != LAST_POS) |=>
         pos_ff == $past(pos_ff) + 1'b1)
   `TFHP_ASSERT(a_drain_after_full, clock, reset,
      accept && ev.emit && !ev.short_hdr && !last_byte |=> sent_ff && (pos_ff == '0))

endmodule

// ===== sv/tfhp_decode.sv =====
module tfhp_decode
   import tfhp_pkg::*;
(
   input  hdr_fields_type fields,
   input  logic           short_hdr,
   input  logic [6:0]     rollover,
   output rsp_fields_type result
);

   logic [15:0] hl;
   logic        old_century;

   always_comb begin
      hl          = (fields.version == SHORT_VERSION) ? SHORT_HEADER_LEN
                                                      : fields.hdr_size;
      old_century = (fields.year >= YEAR_LIMIT) || (fields.year >= {1'b0, rollover});
      result      = '0;
      if (short_hdr) begin
         result.status = STATUS_SHORT;
      end else begin
         result.status            = (hl < MIN_HEADER_LEN || fields.rec_size == '0)
                                    ? STATUS_BAD_LENGTH : STATUS_OK;
         result.format_kind       = kind_of_version(fields.version);
         result.memo_present      = memo_of_version(fields.version);
         result.container_present = fields.flags[2];
         result.index_present     = fields.flags[0];
         result.record_total      = fields.num_records;
         result.header_bytes      = hl;
         result.record_bytes      = fields.rec_size;
         result.full_year         = (old_century ? YEAR_BASE_OLD : YEAR_BASE_NEW)
                                    + {4'b0, fields.year};
         result.update_month      = fields.month;
         result.update_day        = fields.day;
         result.code_page         = page_of_mark(fields.page_mark);
      end
   end

endmodule

// ===== sv/tfhp_out_reg.sv =====
module tfhp_out_reg
   import tfhp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  rsp_fields_type load_data,
   output logic           free,
   output logic           out_valid,
   output rsp_fields_type out_data,
   input  logic           out_ready
);

   logic           valid_ff, valid_in;
   rsp_fields_type data_ff, data_in;

   always_comb begin
      free     = !valid_ff || out_ready;
      valid_in = load ? 1'b1 : (valid_ff && !out_ready);
      data_in  = load ? load_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/table_file_header_parser.sv =====
// table file header parser
// req channel: one header byte per transfer in req_tdata, req_tlast on the
// final byte of the header buffer. bytes are accepted one per cycle while req_tready is high.
// rsp channel: one decoded header per 32 bytes, or a short-header result
// (status 1, all else zero) when req_tlast comes before the 32nd byte.
// bytes after the 32nd are dropped until one with req_tlast, which rearms.
// latency: the result is valid the cycle after the byte that closes it.
// throughput: one byte per cycle, set by the single output register;
// req_tready drops only while a result waits and rsp_tready is low.
// csr_we writes the century rollover (used for two-digit years).
// reset clears position, pending result and sets rollover to 80.
// a stalled result holds rsp_tdata steady until it is taken.
`include "table_file_header_parser_macros.svh"

module table_file_header_parser
   import tfhp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // data_byte
   input  logic                  req_tlast,   // last_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status, format_kind, memo_present, container_present, index_present,
   // record_total, header_bytes, record_bytes, full_year, update_month,
   // update_day, code_page, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [6:0]            csr_wdata
);

   logic           accept;
   logic           free;
   logic [6:0]     rollover_ff, rollover_in;
   hdr_fields_type fields;
   cap_event_type  ev;
   rsp_fields_type result;
   rsp_fields_type rsp_fields;

   assign accept      = req_tvalid && req_tready;
   assign req_tready  = free;
   assign rollover_in = csr_we ? csr_wdata : rollover_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rollover_ff <= ROLLOVER_RESET;
      end else begin
         rollover_ff <= rollover_in;
      end
   end

   tfhp_capture u_capture (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .fields    (fields),
      .ev        (ev)
   );

   tfhp_decode u_decode (
      .fields    (fields),
      .short_hdr (ev.short_hdr),
      .rollover  (rollover_ff),
      .result    (result)
   );

   tfhp_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && ev.emit),
      .load_data (result),
      .free      (free),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_fields),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, rsp_fields};

   `TFHP_ASSERT(a_short_is_bare, clock, reset,
      rsp_tvalid && (rsp_fields.status == STATUS_SHORT) |->
         rsp_fields[RSP_FIELDS_W-1:2] == '0)
   `TFHP_ASSERT(a_ok_lengths, clock, reset,
      rsp_tvalid && (rsp_fields.status == STATUS_OK) |->
         (rsp_fields.header_bytes >= MIN_HEADER_LEN) && (rsp_fields.record_bytes != '0))

endmodule
